// File: hdl/itdr_pkg.sv
// ----------------------------------------------------------------------------
// itdr_pkg: shared types and constants for the integer to radix digits block
// Holds the radix limits, ASCII codes, divider step size and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package itdr_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned STEP_BITS       = 8;   // quotient bits per divider cycle
  localparam int unsigned RADIX_W         = 6;
  localparam int unsigned CHAR_W          = 7;
  localparam int unsigned POS_W           = 5;
  localparam int unsigned MAX_DIGITS      = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_BASE    = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h41;
  localparam logic [POS_W-1:0]   POS_LAST    = 5'(MAX_DIGITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } itdr_state_t;

  // digit value 0..35 to '0'..'9', 'A'..'Z'
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d < DEC_BASE) begin
      digit_ascii = CHAR_ZERO + d_ext;
    end else begin
      digit_ascii = CHAR_A + d_ext - {1'b0, DEC_BASE};
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/int_to_radix_digits_top.sv
// ----------------------------------------------------------------------------
// int_to_radix_digits_top: signed integer to ASCII digits in base 2..36
// Emits one beat per digit, least significant first, by repeated division.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                       | content
//  ---------+-----+-------------------------------+------------------------------
//  s_       | in  | tvalid tready tdata[31:0]     | value (two's complement)
//  m_       | out | tvalid tready tdata tuser tlast| digit_char, position, sign, last
//  radix_   | in  | we wdata[5:0]                 | number base, reset 10
//
//  Each digit is worked out in the shared divider (8 quotient bits per cycle);
//  its remainder and quotient are then captured and the digit is sent as a beat.
//  s_tready is high only between items; a stalled m_ side holds the digit
//  and the next division waits. Synchronous reset returns to idle, radix 10.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_radix_digits_top #(
  parameter int unsigned VALUE_WIDTH = itdr_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [6:0] digit_char, [11:7] digit_position, 0 pad
  output logic             m_tuser,   // [0] is_negative
  output logic             m_tlast,   // last_digit
  input  wire logic        radix_we,
  input  wire logic [5:0]  radix_wdata
);
  import itdr_pkg::*;

  localparam int unsigned MAG_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned DIV_W = ((MAG_W + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam logic        SIGNED_IN = (VALUE_WIDTH <= 32);

  itdr_state_t        state, state_next;
  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] base;
  logic [MAG_W-1:0]   mag;
  logic               neg;
  logic [POS_W-1:0]   pos;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;

  logic               in_beat, out_beat;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_quot;
  logic [RADIX_W-1:0] div_rem;
  logic [RADIX_W-1:0] base_in;
  logic [MAG_W-1:0]   v_low, mag_in;
  logic               neg_in;

  assign in_beat  = s_tvalid & s_tready;
  assign out_beat = m_tvalid & m_tready;

  // clamp radix into 2..36
  always_comb begin
    if (radix < RADIX_MIN) begin
      base_in = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base_in = RADIX_MAX;
    end else begin
      base_in = radix;
    end
  end

  // magnitude in unsigned arithmetic so the most negative value converts exactly
  assign v_low  = s_tdata[MAG_W-1:0];
  assign neg_in = SIGNED_IN & v_low[MAG_W-1];
  assign mag_in = neg_in ? (~v_low + 1'b1) : v_low;

  assign div_dividend = (state == ST_IDLE) ? DIV_W'(mag_in) : DIV_W'(mag);

  itdr_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  ((state == ST_IDLE) ? base_in : base),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) state_next = out_last ? ST_IDLE : ST_DIV;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready  = 1'b0;
    m_tvalid  = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        div_start = s_tvalid;
      end
      ST_DIV: begin
      end
      ST_OUT: begin
        m_tvalid  = 1'b1;
        div_start = m_tready & ~out_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      radix <= RADIX_RESET;
    end else begin
      state <= state_next;
      if (radix_we) radix <= radix_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      base <= base_in;
      neg  <= neg_in;
      mag  <= mag_in;
      pos  <= '0;
    end else if (out_beat) begin
      pos  <= pos + 1'b1;
    end
    if (state == ST_DIV && div_done) begin
      out_char <= digit_ascii(div_rem);
      mag      <= div_quot[MAG_W-1:0];
      out_last <= (div_quot == '0) || (pos == POS_LAST);
    end
  end

  assign m_tdata = {4'b0, pos, out_char};
  assign m_tuser = neg;
  assign m_tlast = out_last;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a digit is pending");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (out_beat && m_tlast) |=> s_tready)
    else $error("block not idle after the last digit");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    (out_beat && !m_tlast) |=> (pos == POS_W'($past(pos) + 1'b1)))
    else $error("digit position did not advance");

endmodule

`default_nettype wire

// File: hdl/itdr_div.sv
// ----------------------------------------------------------------------------
// itdr_div: iterative divider by a small base
// Restoring division of a wide dividend by a 6-bit divisor, STEP_BITS
// quotient bits per cycle; pulses done with quotient and remainder ready.
// ----------------------------------------------------------------------------
`default_nettype none

module itdr_div #(
  parameter int unsigned DIV_W = 4 * itdr_pkg::STEP_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [DIV_W-1:0]             dividend,
  input  wire logic [itdr_pkg::RADIX_W-1:0] divisor,
  output logic                              done,
  output logic [DIV_W-1:0]                  quotient,
  output logic [itdr_pkg::RADIX_W-1:0]      remainder
);
  import itdr_pkg::*;

  localparam int unsigned CHUNKS = DIV_W / STEP_BITS;
  localparam int unsigned CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic [DIV_W-1:0]     work;
  logic [RADIX_W-1:0]   rem;
  logic [CNT_W-1:0]     cnt;
  logic                 run;

  logic [STEP_BITS-1:0] q_bits;
  logic [RADIX_W-1:0]   rem_next;

  // one chunk of dividend bits through a short chain of compare-subtract
  always_comb begin
    logic [STEP_BITS-1:0] chunk;
    logic [RADIX_W:0]     trial;
    chunk    = work[DIV_W-1 -: STEP_BITS];
    rem_next = rem;
    q_bits   = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      trial = {rem_next, chunk[i]};
      if (trial >= {1'b0, divisor}) begin
        rem_next  = RADIX_W'(trial - {1'b0, divisor});
        q_bits[i] = 1'b1;
      end else begin
        rem_next  = RADIX_W'(trial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(CHUNKS - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (run) begin
      // shift the consumed chunk out, quotient bits in at the bottom
      work <= DIV_W'({work, q_bits});
      rem  <= rem_next;
    end
  end

  assign quotient  = work;
  assign remainder = rem;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for int_to_radix_digits_top
// Sends signed 32-bit values in several number bases and checks every digit
// beat (character, position, sign, last mark) against digits worked out in
// the bench, least significant first, under random idling on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import itdr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic              neg;
    logic              last;
  } digit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        radix_we = 1'b0;
  logic [5:0]  radix_wdata = '0;

  digit_t            digits_due[$];
  logic [RADIX_W-1:0] radix_now = RADIX_RESET;
  logic              idle_on = 1'b1;
  logic              hold_sink = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       cycles = 0;
  int unsigned       err_count = 0;

  int_to_radix_digits_top uut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),      // [31:0] value
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),      // [6:0] digit_char, [11:7] digit_position, 0 pad
    .m_tuser    (m_tuser),      // [0] is_negative
    .m_tlast    (m_tlast),
    .radix_we   (radix_we),
    .radix_wdata(radix_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Expected digits of one value in the current base, pushed in output order
  function automatic void predict_digits(input logic [31:0] v, input logic [RADIX_W-1:0] r);
    int unsigned base;
    int unsigned mag;
    int unsigned d;
    int unsigned n;
    digit_t      dg;
    base = 32'((r < RADIX_MIN) ? RADIX_MIN : (r > RADIX_MAX) ? RADIX_MAX : r);
    // two's complement negate in 32 bits keeps the most negative value exact
    mag = v[31] ? (~v + 32'd1) : v;
    n = 0;
    do begin
      d = mag % base;
      mag = mag / base;
      dg.ch = (d < 10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_A + CHAR_W'(d - 10);
      dg.pos = POS_W'(n);
      dg.neg = v[31];
      dg.last = (mag == 0) || (n == MAX_DIGITS - 1);
      digits_due.push_back(dg);
      n++;
    end while (mag != 0 && n < MAX_DIGITS);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    err_count++;
  endtask

  // Receiver: random stall bursts, long hold on request
  always @(posedge clk) begin
    if (hold_sink) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Digit checker
  always @(posedge clk) begin
    digit_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (digits_due.size() == 0) begin
        report_mismatch("unexpected beat, char", int'(m_tdata[6:0]), 0);
      end else begin
        want = digits_due.pop_front();
        if (m_tdata[6:0] !== want.ch)
          report_mismatch("digit_char", int'(m_tdata[6:0]), int'(want.ch));
        if (m_tdata[11:7] !== want.pos)
          report_mismatch("digit_position", int'(m_tdata[11:7]), int'(want.pos));
        if (m_tuser !== want.neg)
          report_mismatch("is_negative", int'(m_tuser), int'(want.neg));
        if (m_tlast !== want.last)
          report_mismatch("last_digit", int'(m_tlast), int'(want.last));
      end
    end
  end

  // Offer one value; returns in the step of the accepting edge
  task automatic send_value(input logic [31:0] v);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    predict_digits(v, radix_now);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] r);
    wait_drained();
    radix_we <= 1'b1;
    radix_wdata <= r;
    @(posedge clk);
    radix_we <= 1'b0;
    radix_now = r;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 100);
      1: v = -$urandom_range(1, 100);
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'd1;
          default: v = 32'd0;
        endcase
      end
      3: v = $urandom >> $urandom_range(0, 31);
      4: v = -($urandom >> $urandom_range(1, 31));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_default_radix();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd10);
    send_value(-32'sd9);
  endtask

  task automatic test_radix_limits();
    set_radix(RADIX_MIN);
    send_value(32'd0);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h5555_5555);
    set_radix(RADIX_MAX);
    send_value(32'd35);
    send_value(32'd36);
    send_value(-32'sd36);
    send_value(32'h8000_0000);
    // out-of-range bases clamp to 2 and 36
    set_radix(6'd0);
    send_value(32'd5);
    set_radix(6'd1);
    send_value(-32'sd6);
    set_radix(6'd37);
    send_value(32'd71);
    set_radix(6'd63);
    send_value(-32'sd1295);
  endtask

  task automatic test_random_radix();
    logic [RADIX_W-1:0] r;
    for (int p = 0; p < 6; p++) begin
      if ($urandom_range(0, 4) == 0) r = RADIX_W'($urandom_range(0, 63));
      else r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
      set_radix(r);
      for (int i = 0; i < 32; i++) send_value(pick_value());
    end
  endtask

  task automatic test_backpressure();
    set_radix(RADIX_MIN);
    fork
      begin
        hold_sink <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink <= 1'b0;
      end
      for (int i = 0; i < 10; i++) send_value(pick_value());
    join
  endtask

  task automatic test_no_idle();
    wait_drained();
    idle_on <= 1'b0;
    set_radix(RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX)));
    for (int i = 0; i < 30; i++) send_value(pick_value());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_radix();
    test_radix_limits();
    test_random_radix();
    test_backpressure();
    test_no_idle();
    wait_drained();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hdl/itdr_pkg.sv
hdl/itdr_div.sv
hdl/int_to_radix_digits_top.sv
dv/tb_top.sv
